@@ hdl/utrb_pkg.sv @@
// Shared types, codes and helpers for the serial ring buffer block.
// No dependencies.
package utrb_pkg;

   localparam int TX_DEPTH = 16;
   localparam int RX_DEPTH = 16;
   localparam int TX_AW    = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_AW    = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;

   localparam logic [2:0] KIND_PUT  = 3'd0;
   localparam logic [2:0] KIND_HEX  = 3'd1;
   localparam logic [2:0] KIND_GET  = 3'd2;
   localparam logic [2:0] KIND_LINE = 3'd3;
   localparam logic [2:0] KIND_TXE  = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam logic [7:0] HI_MASK     = 8'hF0;
   localparam logic [7:0] LO_MASK     = 8'h0F;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_ALPHA = 8'h37;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_byte;
      logic [7:0] line_byte;
      logic       line_valid;
      logic       tx_request;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic hex2;
   } cmd_type;

   typedef struct packed {
      logic hex_cont;
   } dp_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_HEX2
   } state_type;

   function automatic logic [TX_AW-1:0] tx_wrap(input logic [TX_AW-1:0] idx);
      return (idx >= TX_AW'(TX_DEPTH - 1)) ? '0 : idx + TX_AW'(1);
   endfunction

   function automatic logic [RX_AW-1:0] rx_wrap(input logic [RX_AW-1:0] idx);
      return (idx >= RX_AW'(RX_DEPTH - 1)) ? '0 : idx + RX_AW'(1);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return ({4'd0, nib} < 8'd10) ? ({4'd0, nib} + ASCII_ZERO)
                                   : ({4'd0, nib} + ASCII_ALPHA);
   endfunction

endpackage

@@ hdl/utrb_ctrl.sv @@
// Sequencer for the ring buffer block: handshakes and step commands.
// Depends on utrb_pkg.
module utrb_ctrl import utrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!rsp_valid_ff) begin
               cmd.exec = 1'b1;
               if (dp_status.hex_cont) begin
                  state_in = S_HEX2;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_HEX2: begin
            cmd.hex2     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/utrb_dp.sv @@
// Datapath: transmit and receive rings, pointers and result register.
// Depends on utrb_pkg.
module utrb_dp import utrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  cmd_type       cmd,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   logic [7:0]       tx_mem [TX_DEPTH];
   logic [7:0]       rx_mem [RX_DEPTH];
   logic [7:0]       tx_rd_ff, rx_rd_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in, tx_nxt, tx_tnxt;
   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in, rx_nxt;
   logic             tx_pending_ff, tx_pending_in;
   logic             tx_we, rx_we;
   logic [7:0]       tx_wdata, hex_hi, hex_lo;
   logic             tx_full, tx_empty, rx_full, rx_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         tx_pending_ff <= 1'b0;
      end else begin
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         tx_pending_ff <= tx_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[tx_head_ff] <= tx_wdata;
      tx_rd_ff <= tx_mem[tx_tail_ff];
   end

   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_head_ff] <= req_ff.data;
      rx_rd_ff <= rx_mem[rx_tail_ff];
   end

   assign tx_nxt   = tx_wrap(tx_head_ff);
   assign tx_tnxt  = tx_wrap(tx_tail_ff);
   assign rx_nxt   = rx_wrap(rx_head_ff);
   assign tx_full  = (tx_nxt == tx_tail_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);
   assign rx_full  = (rx_nxt == rx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign hex_hi   = hex_digit(4'((req_ff.data & HI_MASK) >> 4));
   assign hex_lo   = hex_digit(4'(req_ff.data & LO_MASK));

   always_comb begin
      tx_head_in         = tx_head_ff;
      tx_tail_in         = tx_tail_ff;
      rx_head_in         = rx_head_ff;
      rx_tail_in         = rx_tail_ff;
      tx_pending_in      = tx_pending_ff;
      tx_we              = 1'b0;
      rx_we              = 1'b0;
      tx_wdata           = hex_lo;
      rsp_in             = rsp_ff;
      dp_status.hex_cont = 1'b0;
      if (cmd.exec) begin
         rsp_in = '0;
         unique case (req_ff.kind)
            KIND_PUT, KIND_HEX: begin
               if (tx_full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  tx_we              = 1'b1;
                  tx_wdata           = (req_ff.kind == KIND_PUT) ? req_ff.data : hex_hi;
                  tx_head_in         = tx_nxt;
                  tx_pending_in      = 1'b1;
                  dp_status.hex_cont = (req_ff.kind == KIND_HEX);
               end
            end
            KIND_GET: begin
               if (rx_empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.read_byte = rx_rd_ff;
                  rx_tail_in       = rx_wrap(rx_tail_ff);
               end
            end
            KIND_LINE: begin
               if (rx_full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  rx_we      = 1'b1;
                  rx_head_in = rx_nxt;
               end
            end
            KIND_TXE: begin
               if (tx_empty) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.line_byte  = tx_rd_ff;
                  rsp_in.line_valid = 1'b1;
                  tx_tail_in        = tx_tnxt;
                  if (tx_tnxt == tx_head_ff) tx_pending_in = 1'b0;
               end
            end
            default: ;
         endcase
         rsp_in.tx_request = tx_pending_in;
      end else if (cmd.hex2) begin
         if (tx_full) begin
            rsp_in.status = STAT_FULL;
         end else begin
            tx_we         = 1'b1;
            tx_head_in    = tx_nxt;
            tx_pending_in = 1'b1;
         end
         rsp_in.tx_request = tx_pending_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/uart_tx_rx_ring_buffers.sv @@
// Top level of the serial transmit/receive ring buffer block.
// Depends on utrb_pkg, utrb_ctrl and utrb_dp.
//
// Each request word is one operation on a transmit or receive byte ring (each
// ring keeps one slot free, so it holds depth-1 bytes) and returns exactly one
// response word. A word is captured into the request register when it is
// accepted and executed in the EXEC state; a hex put writes its second digit
// in a further HEX2 step, since both digits go through the single write port
// of the transmit ring. Ring reads come from a registered read of the entry at
// the read pointer, prefetched before execution. A response waiting on
// rsp_ready does not block the next request from being taken; execution of
// that request waits until the response register is free.
module uart_tx_rx_ring_buffers import utrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type       cmd;
   dp_status_type dp_status;

   utrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   utrb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in progress");

   a_line_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.line_valid) |-> (rsp_data.status == STAT_OK))
      else $error("line byte handed out with a failing status");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |->
      (!rsp_data.line_valid && rsp_data.read_byte == 8'd0 && rsp_data.line_byte == 8'd0))
      else $error("failing response carries data");

   a_pop_left_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_OK && !rsp_data.line_valid &&
       rsp_data.read_byte == 8'd0 && cmd.exec) |-> 1'b0)
      else $error("execution started while a response is pending");

endmodule
